@@ rtl/tsdt_pkg.sv @@
// Shared types and constants for the task sleep deadline table.
`timescale 1ns / 1ps
`default_nettype none

package tsdt_pkg;

   localparam int TSDT_TASKS = 8;

   typedef enum logic [1:0] {
      ACT_SLEEP = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_WAKE  = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_RUNNABLE = 2'd0,
      MODE_SLEEP    = 2'd1,
      MODE_DEEP     = 2'd2
   } mode_type;

   // Command token handed from cell to cell along the chain.
   typedef struct packed {
      logic       valid;
      action_type action;
      logic [2:0] id;
      logic       intr;
      logic [7:0] woken;
      mode_type   mode;
   } tok_type;

endpackage

`default_nettype wire

@@ rtl/tsdt_cell.sv @@
// One task entry of the sleep table: holds deadline, interrupt flag and mode.
`timescale 1ns / 1ps
`default_nettype none

module tsdt_cell
   import tsdt_pkg::*;
#(
   parameter int IDX = 0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] now,
   input  wire logic [63:0] deadline,
   input  wire tok_type     tok_in,
   output tok_type          tok_out
);

   localparam logic [7:0] BitMask = (IDX < 8) ? 8'(1 << IDX) : 8'd0;

   logic [63:0] dl_ff, dl_in;
   logic        intr_ff, intr_in;
   mode_type    mode_ff, mode_in;
   tok_type     tok_ff, tok_in_next;
   logic        hit;
   logic        wake;

   always_comb begin
      hit     = tok_in.valid && (IDX < 8) && (tok_in.id == 3'(IDX));
      dl_in   = dl_ff;
      intr_in = intr_ff;
      mode_in = mode_ff;
      wake    = 1'b0;
      if (tok_in.valid) begin
         case (tok_in.action)
            ACT_SLEEP: begin
               if (hit) begin
                  dl_in   = deadline;
                  intr_in = tok_in.intr;
                  mode_in = tok_in.intr ? MODE_SLEEP : MODE_DEEP;
               end
            end
            ACT_TICK: begin
               if (mode_ff != MODE_RUNNABLE && now > dl_ff) begin
                  wake = 1'b1;
               end
            end
            ACT_WAKE: begin
               if (hit && (dl_ff < now || intr_ff)) begin
                  wake = 1'b1;
               end
            end
            ACT_QUERY: begin
               if (hit && mode_ff != MODE_RUNNABLE && !(dl_ff > now)) begin
                  wake = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (wake) begin
         mode_in = MODE_RUNNABLE;
      end
      tok_in_next = tok_in;
      if (wake && mode_ff != MODE_RUNNABLE) begin
         tok_in_next.woken = tok_in.woken | BitMask;
      end
      if (hit) begin
         tok_in_next.mode = mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff        <= '0;
         intr_ff      <= 1'b0;
         mode_ff      <= MODE_RUNNABLE;
         tok_ff.valid <= 1'b0;
      end else begin
         dl_ff   <= dl_in;
         intr_ff <= intr_in;
         mode_ff <= mode_in;
         tok_ff  <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

@@ rtl/task_sleep_deadline_table_core.sv @@
// Top level of the task sleep deadline table: command sequencer and cell chain.
// A new item is taken only while idle; busy stays high through the result strobe.
// The token walks one cell per cycle.
// The multiply and the 64-bit deadline add are each registered before the walk.
// Reset (synchronous, active high): tick count zero, all tasks runnable,
// deadlines zero, ticks_per_ms one. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module task_sleep_deadline_table_core
   import tsdt_pkg::*;
#(
   parameter int TASKS = TSDT_TASKS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [2:0]  req_task_id,
   input  wire logic [31:0] req_duration_ms,
   input  wire logic        req_interruptible,
   // result channel
   output logic             rsp_valid,
   output logic             rsp_task_sleeping,
   output logic [1:0]       rsp_task_mode,
   output logic [7:0]       rsp_woken_mask,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   // One-hot sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MULT   = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_LAUNCH = 5'b01000,
      ST_SCAN   = 5'b10000
   } state_type;

   state_type   state_ff, state_in;

   // Captured item fields.
   action_type  act_ff;
   logic [2:0]  id_ff;
   logic [31:0] ms_ff;
   logic        intr_ff;

   logic [15:0] tpm_ff;
   logic [47:0] prod_ff, prod_in;
   logic [63:0] dl_ff, dl_in;
   logic [63:0] now_ff, now_in;

   tok_type     tok_launch;
   tok_type     tok [TASKS+1];

   // ------------------------------------------------------------------
   // Sequencer: accept, multiply, add, then launch a token down the chain
   // and wait for it to fall off the far end.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_MULT;
         ST_MULT:   state_in = ST_SUM;
         ST_SUM:    state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_SCAN;
         ST_SCAN:   if (tok[TASKS].valid) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // Duration in ticks: 32 x 16 product, registered before the add.
   assign prod_in = {16'd0, ms_ff} * {32'd0, tpm_ff};

   // Deadline from the count before any tick; a tick advances the count here
   // so the scan compares against the new value.
   always_comb begin
      dl_in  = now_ff + {16'd0, prod_ff};
      now_in = now_ff;
      if (state_ff == ST_SUM && act_ff == ACT_TICK) begin
         now_in = now_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tpm_ff   <= 16'd1;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         now_ff   <= now_in;
         // Register writes must arrive only while idle; the block itself does not enforce this.
         if (csr_wr_en) begin
            tpm_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         act_ff  <= action_type'(req_action);
         id_ff   <= req_task_id;
         ms_ff   <= req_duration_ms;
         intr_ff <= req_interruptible;
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_SUM) begin
         dl_ff <= dl_in;
      end
   end

   // ------------------------------------------------------------------
   // Cell chain: the token enters cell 0 during launch and advances one
   // cell per cycle; each cell updates its own task entry as it passes.
   // An out-of-range task matches no cell, so the token keeps mode runnable.
   // ------------------------------------------------------------------
   always_comb begin
      tok_launch.valid  = (state_ff == ST_LAUNCH);
      tok_launch.action = act_ff;
      tok_launch.id     = id_ff;
      tok_launch.intr   = intr_ff;
      tok_launch.woken  = 8'd0;
      tok_launch.mode   = MODE_RUNNABLE;
   end

   assign tok[0] = tok_launch;

   for (genvar gi = 0; gi < TASKS; gi++) begin : g_chain
      tsdt_cell #(
         .IDX (gi)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .now      (now_ff),
         .deadline (dl_ff),
         .tok_in   (tok[gi]),
         .tok_out  (tok[gi+1])
      );
   end

   // The last cell's token register is the result register.
   assign rsp_valid         = tok[TASKS].valid;
   assign rsp_task_mode     = tok[TASKS].mode;
   assign rsp_task_sleeping = (tok[TASKS].mode != MODE_RUNNABLE);
   assign rsp_woken_mask    = tok[TASKS].woken;

`ifndef SYNTHESIS
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("sequencer not idle after result");

   a_result_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a command");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && act_ff == ACT_TICK) |=> (now_ff == $past(now_ff) + 64'd1))
      else $error("tick did not advance the count");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !tok[TASKS].valid)
      else $error("token in chain while idle");
`endif

endmodule

`default_nettype wire
